// File: design/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, register codes and the character glyph table for the
// four-digit multiplexed seven-segment scan driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

    localparam int TEXT_DEPTH = 32;
    localparam int ADDR_W     = $clog2(TEXT_DEPTH);
    // signed position into the store, wide enough for len-1-p and window+3
    localparam int POS_W      = ADDR_W + 2;
    localparam int LEN_W      = 6;
    localparam int GLYPH_N    = 42;
    localparam int GLYPH_W    = $clog2(GLYPH_N);

    // configuration register indexes
    localparam logic [2:0] CFG_COMMON_ANODE  = 3'd0;
    localparam logic [2:0] CFG_SCROLL_ENABLE = 3'd1;
    localparam logic [2:0] CFG_SCROLL_PERIOD = 3'd2;
    localparam logic [2:0] CFG_TEXT_LENGTH   = 3'd3;
    localparam logic [2:0] CFG_DP_DIGIT      = 3'd4;

    // item kinds carried on tuser
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [2:0] POINT_NONE = 3'b111;

    typedef struct packed {
        logic        common_anode;
        logic        scroll_enable;
        logic [7:0]  scroll_period;
        logic [5:0]  text_length;
        logic [2:0]  dp_digit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        digit;
        logic              pos_ok;
        logic [ADDR_W-1:0] addr;
    } t_scan;

    typedef struct packed {
        logic       hit;
        logic [7:0] pattern;
    } t_glyph;

    // a..g in bits 0..6, point in bit 7
    localparam logic [7:0] GLYPHS [GLYPH_N] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h06, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h00, 8'h40, 8'h08, 8'h80, 8'h41, 8'h63
    };

    function automatic t_glyph glyph_lookup(input logic [7:0] code);
        logic [GLYPH_W-1:0] gi;
        logic               hit;
        t_glyph             r;
        hit = 1'b1;
        gi  = '0;
        if (code >= 8'h30 && code <= 8'h39) begin
            gi = GLYPH_W'(code - 8'h30);
        end else if (code >= 8'h61 && code <= 8'h7A) begin
            gi = GLYPH_W'(code - 8'h61 + 8'd10);
        end else if (code >= 8'h41 && code <= 8'h5A) begin
            gi = GLYPH_W'(code - 8'h41 + 8'd10);
        end else begin
            case (code)
                8'h20:   gi = GLYPH_W'(36);  // space
                8'h2D:   gi = GLYPH_W'(37);  // dash
                8'h5F:   gi = GLYPH_W'(38);  // underscore
                8'h2E:   gi = GLYPH_W'(39);  // point
                8'h3D:   gi = GLYPH_W'(40);  // equals
                8'h2A:   gi = GLYPH_W'(41);  // degree
                default: hit = 1'b0;
            endcase
        end
        r.hit     = hit;
        r.pattern = GLYPHS[gi];
        return r;
    endfunction

endpackage

// File: design/sssd_store.sv
// ----------------------------------------------------------------------------
// sssd_store
// Character store: one write port, one combinational read port, cleared
// at reset.
// ----------------------------------------------------------------------------
module sssd_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [sssd_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [sssd_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import sssd_pkg::*;

    logic [7:0] r_text [TEXT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TEXT_DEPTH; i++) begin
                r_text[i] <= 8'h00;
            end
        end else if (i_we) begin
            r_text[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_text[i_raddr];

endmodule

// File: design/sssd_scan.sv
// ----------------------------------------------------------------------------
// sssd_scan
// Digit scan, scroll window and tick counter; works out which store
// position the current digit shows.
// ----------------------------------------------------------------------------
module sssd_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sssd_pkg::t_cfg  i_cfg,
    input  logic            i_tick,
    output sssd_pkg::t_scan o_scan
);
    import sssd_pkg::*;

    logic [1:0]       r_digit;
    logic [ADDR_W-1:0] r_window;
    logic [7:0]       r_ticks;
    logic [1:0]       n_digit;
    logic [ADDR_W-1:0] n_window;
    logic [7:0]       n_ticks;

    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    logic [7:0]       ticks_inc;
    logic [ADDR_W:0]  window_inc;

    // clamp length to 1..TEXT_DEPTH
    always_comb begin
        if (i_cfg.text_length == '0) begin
            len = LEN_W'(1);
        end else if (i_cfg.text_length > LEN_W'(TEXT_DEPTH)) begin
            len = LEN_W'(TEXT_DEPTH);
        end else begin
            len = i_cfg.text_length;
        end
    end

    always_comb begin
        if (i_cfg.scroll_enable) begin
            pos = POS_W'(r_window) + POS_W'(3) - POS_W'(r_digit);
        end else begin
            pos = POS_W'(len) - POS_W'(1) - POS_W'(r_digit);
        end
    end

    assign o_scan.digit  = r_digit;
    assign o_scan.pos_ok = (pos[POS_W-1:ADDR_W] == '0);
    assign o_scan.addr   = pos[ADDR_W-1:0];

    assign ticks_inc  = r_ticks + 8'd1;
    assign window_inc = (ADDR_W+1)'(r_window) + (ADDR_W+1)'(1);

    always_comb begin
        n_digit  = r_digit;
        n_window = r_window;
        n_ticks  = r_ticks;
        if (i_tick) begin
            // short text wraps the scan early
            if (r_digit == 2'd3 || len == LEN_W'(r_digit) + LEN_W'(1)) begin
                n_digit = 2'd0;
            end else begin
                n_digit = r_digit + 2'd1;
            end
            if (i_cfg.scroll_enable) begin
                if (ticks_inc > i_cfg.scroll_period) begin
                    n_ticks = 8'd0;
                    if (POS_W'(window_inc) + POS_W'(3) >= POS_W'(len)) begin
                        n_window = '0;
                    end else begin
                        n_window = window_inc[ADDR_W-1:0];
                    end
                end else begin
                    n_ticks = ticks_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit  <= 2'd0;
            r_window <= '0;
            r_ticks  <= 8'd0;
        end else begin
            r_digit  <= n_digit;
            r_window <= n_window;
            r_ticks  <= n_ticks;
        end
    end

endmodule

// File: design/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Four-digit multiplexed seven-segment driver with a 32-character store.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser selects the item kind. A write item stores
// char_code at char_index and gives no output. A tick item lights the next
// digit, rightmost first, and gives one output item with the segment levels
// and a one-hot digit enable (bit 3 rightmost).
// Config channel: i_cfg_index picks common_anode, scroll_enable,
// scroll_period, text_length or the decimal point digit; writes are always
// taken and should only be made while no items are in flight.
// Pipeline: an accepted item waits in the input register, then its
// result is loaded into the output register. One item per cycle is
// sustained while the output is not stalled; the store lookup, glyph
// table and point logic sit between those two registers.
// Reset clears the store, the scan and scroll counters, and the config
// registers to their defaults; no clearing pass is needed.
// A stalled output holds its item; a following tick then waits in the input
// register, writes ahead of it still drain during the stall, and s_tready
// drops only when a tick is blocked there.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_index[4:0], char_code[12:5], zero pad
    input  logic        s_tuser,   // command
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // segments[7:0], digit_enable[11:8], zero pad
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import sssd_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic             r_in_cmd;
    logic [ADDR_W-1:0] r_in_index;
    logic [7:0]       r_in_code;
    logic             r_out_valid;
    logic [7:0]       r_out_seg;
    logic [3:0]       r_out_en;
    logic [7:0]       r_last_pattern;

    logic             s_take;
    logic             fire;
    logic             tick;
    logic             wr;
    t_scan            scan;
    logic [7:0]       rdata;
    t_glyph           glyph;
    logic [7:0]       n_seg;
    logic             lit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.common_anode  <= 1'b0;
            r_cfg.scroll_enable <= 1'b0;
            r_cfg.scroll_period <= 8'd100;
            r_cfg.text_length   <= 6'd1;
            r_cfg.dp_digit      <= POINT_NONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COMMON_ANODE:  r_cfg.common_anode  <= i_cfg_data[0];
                CFG_SCROLL_ENABLE: r_cfg.scroll_enable <= i_cfg_data[0];
                CFG_SCROLL_PERIOD: r_cfg.scroll_period <= i_cfg_data;
                CFG_TEXT_LENGTH:   r_cfg.text_length   <= i_cfg_data[5:0];
                CFG_DP_DIGIT:      r_cfg.dp_digit      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // writes never need the output slot
    assign fire     = r_in_valid && (r_in_cmd == CMD_WRITE || !r_out_valid || m_tready);
    assign tick     = fire && (r_in_cmd == CMD_TICK);
    assign wr       = fire && (r_in_cmd == CMD_WRITE);
    assign s_tready = !r_in_valid || fire;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_cmd   <= s_tuser;
            r_in_index <= s_tdata[ADDR_W-1:0];
            r_in_code  <= s_tdata[12:5];
        end
    end

    sssd_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr),
        .i_waddr (r_in_index),
        .i_wdata (r_in_code),
        .i_raddr (scan.addr),
        .o_rdata (rdata)
    );

    sssd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_tick  (tick),
        .o_scan  (scan)
    );

    assign glyph = glyph_lookup(rdata);
    assign lit   = !r_cfg.dp_digit[2] && (r_cfg.dp_digit[1:0] == scan.digit);

    always_comb begin
        // unmapped or off-text characters repeat the last driven pattern
        if (scan.pos_ok && glyph.hit) begin
            n_seg = glyph.pattern ^ {8{r_cfg.common_anode}};
        end else begin
            n_seg = r_last_pattern;
        end
        if (r_cfg.dp_digit != POINT_NONE) begin
            n_seg[7] = lit ^ r_cfg.common_anode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_last_pattern <= 8'h00;
        end else if (tick) begin
            r_out_valid    <= 1'b1;
            r_last_pattern <= n_seg;
        end else if (m_tready) begin
            r_out_valid    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out_seg <= n_seg;
            r_out_en  <= 4'b1000 >> scan.digit;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_out_en, r_out_seg};

endmodule

// File: design/sssd_checker.sv
// ----------------------------------------------------------------------------
// sssd_checker
// Port-level checks on the output stream and the config ready of the scan driver.
// ----------------------------------------------------------------------------
module sssd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        o_cfg_ready
);

    // a shown item must hold while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot(m_tdata[11:8]))
        else $error("digit enable is not one-hot");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[15:12] == 4'b0000) && o_cfg_ready)
        else $error("output padding set or config port not ready");

endmodule

bind seven_segment_scan_driver sssd_checker u_sssd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .o_cfg_ready (o_cfg_ready)
);

// File: verif/seven_segment_scan_driver_test.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_test
// Self-checking bench for the four-digit scan driver. Character writes and
// refresh ticks go in on the input stream, and a behavioral model of the
// display predicts every digit item. Each output item is compared with the
// oldest prediction. The run covers directed glyph, point, short-text and
// scroll cases, then random phases under many register settings, with random
// idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_test;
    import sssd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enable;
    } t_digit;

    // a..g in bits 0..6, point in bit 7; digits, letters, then specials
    localparam bit [7:0] SEG_FONT [42] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h74, 8'h06, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h00, 8'h40, 8'h08, 8'h80, 8'h41, 8'h63
    };
    localparam byte SPECIALS [6] = '{" ", "-", "_", ".", "=", "*"};

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // char_index[4:0], char_code[12:5], zero pad
    logic        s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // segments[7:0], digit_enable[11:8], zero pad
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    seven_segment_scan_driver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // display model: registers
    bit       anode_mode;
    bit       scroll_mode;
    bit [7:0] scroll_limit;
    bit [5:0] length_reg;
    bit [2:0] point_reg;
    // display model: scan state
    bit [1:0] scan_pos;
    int       window_pos;
    bit [7:0] scroll_ticks;
    bit [7:0] text_copy [TEXT_DEPTH];
    bit [7:0] prev_segments;

    t_digit pending_digits [$];
    t_digit got_digit;
    t_digit want_digit;

    int  n_errors;
    int  n_ticks;
    int  n_writes;
    int  n_regs;
    int  n_checked;
    bit  steady;     // no idling on either side while set
    int  sink_hold;  // cycles the output side stays stalled

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("timeout at %0t", $time);
        $display("seven_segment_scan_driver verification failed");
        $finish;
    end

    function automatic bit [8:0] char_glyph(input bit [7:0] code);
        bit [7:0] c;
        c = code;
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        if (c >= "0" && c <= "9") return {1'b1, SEG_FONT[c - "0"]};
        if (c >= "a" && c <= "z") return {1'b1, SEG_FONT[c - "a" + 10]};
        case (c)
            " ":     return {1'b1, SEG_FONT[36]};
            "-":     return {1'b1, SEG_FONT[37]};
            "_":     return {1'b1, SEG_FONT[38]};
            ".":     return {1'b1, SEG_FONT[39]};
            "=":     return {1'b1, SEG_FONT[40]};
            "*":     return {1'b1, SEG_FONT[41]};
            default: return 9'd0;
        endcase
    endfunction

    function automatic t_digit next_digit_pattern();
        int       len;
        int       p;
        int       pos;
        bit [7:0] code;
        bit [8:0] g;
        bit [7:0] seg;
        bit       lit;
        t_digit   r;
        len = int'(length_reg);
        if (len < 1) len = 1;
        if (len > TEXT_DEPTH) len = TEXT_DEPTH;
        p = int'(scan_pos);
        pos = scroll_mode ? window_pos + 3 - p : len - 1 - p;
        code = (pos < 0 || pos >= TEXT_DEPTH) ? 8'h00 : text_copy[pos];
        g = char_glyph(code);
        // unmapped code repeats what was driven last
        if (g[8]) seg = anode_mode ? ~g[7:0] : g[7:0];
        else seg = prev_segments;
        if (point_reg != POINT_NONE) begin
            // negative positions other than none never light
            lit = !point_reg[2] && (int'(point_reg[1:0]) == p);
            seg[7] = lit ^ anode_mode;
        end
        prev_segments = seg;
        r.segments = seg;
        r.digit_enable = 4'(4'b1000 >> p);
        if (p == 3 || len == p + 1) scan_pos = 2'd0;
        else scan_pos = 2'(p + 1);
        if (scroll_mode) begin
            scroll_ticks = scroll_ticks + 8'd1;
            if (scroll_ticks > scroll_limit) begin
                scroll_ticks = 8'd0;
                window_pos++;
                if (window_pos >= len - 3) window_pos = 0;
            end
        end
        return r;
    endfunction

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got_digit.segments = m_tdata[7:0];
                got_digit.digit_enable = m_tdata[11:8];
                if (pending_digits.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected item segments=%h enable=%b", $time,
                             got_digit.segments, got_digit.digit_enable);
                end else begin
                    want_digit = pending_digits.pop_front();
                    n_checked++;
                    if (got_digit.segments !== want_digit.segments) begin
                        n_errors++;
                        $display("%0t: segments expected %h actual %h", $time,
                                 want_digit.segments, got_digit.segments);
                    end
                    if (got_digit.digit_enable !== want_digit.digit_enable) begin
                        n_errors++;
                        $display("%0t: digit_enable expected %b actual %b", $time,
                                 want_digit.digit_enable, got_digit.digit_enable);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                n_regs++;
                case (i_cfg_index)
                    CFG_COMMON_ANODE:  anode_mode = i_cfg_data[0];
                    CFG_SCROLL_ENABLE: scroll_mode = i_cfg_data[0];
                    CFG_SCROLL_PERIOD: scroll_limit = i_cfg_data;
                    CFG_TEXT_LENGTH:   length_reg = i_cfg_data[5:0];
                    CFG_DP_DIGIT:      point_reg = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_WRITE) begin
                    n_writes++;
                    text_copy[s_tdata[4:0]] = s_tdata[12:5];
                end else begin
                    n_ticks++;
                    pending_digits.push_back(next_digit_pattern());
                end
            end
        end
    end

    // output side: random stalls, or a forced stall of sink_hold cycles
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 26);
        end
    end

    task automatic send_item(input logic cmd, input logic [4:0] idx, input logic [7:0] code);
        while (!steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, code, idx};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic put_char(input logic [4:0] idx, input logic [7:0] code);
        send_item(CMD_WRITE, idx, code);
    endtask

    task automatic tick(input int count);
        repeat (count) send_item(CMD_TICK, 5'($urandom), 8'($urandom));
    endtask

    // wait for every predicted digit, then let in-flight writes settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_regs(input bit ca, input bit scroll, input bit [7:0] period,
                            input bit [5:0] len, input bit [2:0] point);
        drain();
        cfg_write(CFG_COMMON_ANODE, {7'd0, ca});
        cfg_write(CFG_SCROLL_ENABLE, {7'd0, scroll});
        cfg_write(CFG_SCROLL_PERIOD, period);
        cfg_write(CFG_TEXT_LENGTH, {2'd0, len});
        cfg_write(CFG_DP_DIGIT, {5'd0, point});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [7:0] random_char();
        if ($urandom_range(99) < 25) return 8'($urandom);
        case ($urandom_range(3))
            0:       return 8'("0" + $urandom_range(9));
            1:       return 8'("a" + $urandom_range(25));
            2:       return 8'("A" + $urandom_range(25));
            default: return SPECIALS[$urandom_range(5)];
        endcase
    endfunction

    task automatic test_reset_state();
        // empty store: every digit repeats the blank reset pattern
        tick(2);
    endtask

    task automatic test_glyphs_fixed();
        set_regs(1'b0, 1'b0, 8'd100, 6'd4, POINT_NONE);
        put_char(5'd0, "8");
        put_char(5'd1, "a");
        put_char(5'd2, "Z");
        put_char(5'd3, "*");
        put_char(5'd31, 8'hFF);
        tick(4);
        // unmapped code on the rightmost digit keeps the previous pattern
        put_char(5'd3, 8'h00);
        tick(2);
    endtask

    task automatic test_point_and_anode();
        set_regs(1'b1, 1'b0, 8'd100, 6'd4, 3'd2);
        tick(2);
        set_regs(1'b0, 1'b0, 8'd100, 6'd4, 3'(-2));
        tick(2);
    endtask

    task automatic test_short_text();
        // zero length is held at one, so the scan wraps back to the rightmost digit
        set_regs(1'b0, 1'b0, 8'd100, 6'd0, POINT_NONE);
        tick(2);
    endtask

    task automatic test_scroll_wrap();
        set_regs(1'b0, 1'b1, 8'd0, 6'd5, 3'd0);
        put_char(5'd4, "-");
        tick(6);
    endtask

    task automatic run_phase(input int count);
        int len;
        int k;
        len = (length_reg == 0) ? 1 : ((length_reg > TEXT_DEPTH) ? TEXT_DEPTH : length_reg);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 30) begin
                if ($urandom_range(99) < 70) put_char(5'($urandom_range(len - 1)), random_char());
                else put_char(5'($urandom), random_char());
            end else begin
                tick(1);
            end
        end
    endtask

    task automatic test_random_settings();
        int       ph;
        bit [7:0] period;
        bit [5:0] len;
        for (ph = 0; ph < 14; ph++) begin
            case (ph)
                0: set_regs(1'b0, 1'b1, 8'd0, 6'd32, POINT_NONE);
                1: set_regs(1'b1, 1'b1, 8'd255, 6'd63, 3'd3);
                2: set_regs(1'b0, 1'b0, 8'd0, 6'd0, 3'd0);
                3: set_regs(1'b1, 1'b1, 8'd1, 6'd3, 3'(-4));
                default: begin
                    case ($urandom_range(3))
                        0:       period = 8'd0;
                        1:       period = 8'd1;
                        2:       period = 8'($urandom_range(2, 6));
                        default: period = 8'($urandom);
                    endcase
                    if ($urandom_range(99) < 80) len = 6'($urandom_range(1, 32));
                    else len = 6'($urandom);
                    set_regs(1'($urandom), 1'($urandom), period, len, 3'($urandom));
                end
            endcase
            steady = (ph == 6);
            run_phase(50);
            steady = 1'b0;
        end
    endtask

    task automatic test_output_stall();
        set_regs(1'b0, 1'b1, 8'd2, 6'd8, 3'd1);
        @(negedge i_clk);
        sink_hold = 80;
        // ticks pile up behind the stalled output until the input stalls
        run_phase(40);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_TICK;
        m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COMMON_ANODE;
        i_cfg_data = '0;
        anode_mode = 1'b0;
        scroll_mode = 1'b0;
        scroll_limit = 8'd100;
        length_reg = 6'd1;
        point_reg = POINT_NONE;
        scan_pos = 2'd0;
        window_pos = 0;
        scroll_ticks = 8'd0;
        foreach (text_copy[i]) text_copy[i] = 8'h00;
        prev_segments = 8'h00;
        steady = 1'b0;
        sink_hold = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_glyphs_fixed();
        test_point_and_anode();
        test_short_text();
        test_scroll_wrap();
        test_random_settings();
        test_output_stall();

        drain();
        repeat (10) @(negedge i_clk);
        $display("ran %0d ticks and %0d character writes over %0d register writes",
                 n_ticks, n_writes, n_regs);
        $display("compared %0d digit items, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && pending_digits.size() == 0) begin
            $display("seven_segment_scan_driver verification clean");
        end else begin
            $display("seven_segment_scan_driver verification failed");
        end
        $finish;
    end

endmodule
